/* rtl/rar_pkg.sv */
// shared types and constants for the rational arithmetic reduce block
package rar_pkg;

	localparam int WORD_BITS = 64;
	localparam int DIV_CNT_BITS = 6;

	typedef enum logic [1:0] {
		OP_REDUCE = 2'd0,
		OP_ADD    = 2'd1,
		OP_MUL    = 2'd2,
		OP_POW    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_ZERO_DEN = 2'd1,
		STS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_RED0,
		ST_RED1,
		ST_RED2,
		ST_RED3,
		ST_DIV,
		ST_MUL,
		ST_FB,
		ST_FA,
		ST_M1,
		ST_M2,
		ST_A1,
		ST_A2,
		ST_A3,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_FINAL
	} state_t;

endpackage

/* rtl/rar_if.sv */
// item channel interfaces for the rational arithmetic reduce block
interface rar_in_if #(parameter int OPERAND_BITS = 16);
	logic                           valid;
	logic                           ready;
	logic [1:0]                     opcode;
	logic signed [OPERAND_BITS-1:0] num_a;
	logic signed [OPERAND_BITS-1:0] den_a;
	logic signed [OPERAND_BITS-1:0] num_b;
	logic signed [OPERAND_BITS-1:0] den_b;
	logic [3:0]                     exponent;

	modport source (output valid, opcode, num_a, den_a, num_b, den_b, exponent, input ready);
	modport sink (input valid, opcode, num_a, den_a, num_b, den_b, exponent, output ready);
endinterface

interface rar_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] res_num;
	logic [62:0]        res_den;
	logic [1:0]         status;

	modport source (output valid, res_num, res_den, status, input ready);
	modport sink (input valid, res_num, res_den, status, output ready);
endinterface

/* rtl/rational_arith_reduce_top.sv */
// rational arithmetic unit: reduce, add, multiply, power with gcd reduction
// one item at a time; ready only while idle. latency is data dependent:
// each gcd remainder step and each quotient takes one restoring
// division and each product one shift-add multiply, so a zero
// denominator item is shortest and a power item can be the longest.
// arst_n clears the sequencer and the output valid; no other reset state.
module rational_arith_reduce_top
	import rar_pkg::*;
#(
	parameter int OPERAND_BITS = 16,
	parameter int MAX_EXPONENT = 15
) (
	input logic      clk,
	input logic      arst_n,
	rar_in_if.sink   din,
	rar_out_if.source dout
);

	localparam int OB  = OPERAND_BITS;
	localparam int MW  = WORD_BITS + OB;
	localparam int MCW = $clog2(OB);
	localparam int EW  = $clog2(MAX_EXPONENT + 1);

	state_t state_q, state_d;
	state_t ret_q, red_ret_q;

	// captured operands, magnitudes and signs
	opcode_t        op_q;
	logic [OB-1:0]  an_q, ad_q, bn_q, bd_q;
	logic           aneg_q, bneg_q;
	logic [EW-1:0]  cnt_q;
	status_t        sts_q;

	// working fraction and temporaries
	logic [63:0]    wn_q, wd_q, t1_q, t2_q, gy_q;
	logic           wneg_q;

	// shared restoring divider
	logic [64:0]    dv_rem_q;
	logic [63:0]    dv_quo_q, dv_den_q;
	logic [DIV_CNT_BITS-1:0] dv_cnt_q;
	logic [64:0]    dv_sh, dv_rem_n;
	logic           dv_ge;

	// shared shift-add multiplier
	logic [MW-1:0]  mu_acc_q, mu_acc_n;
	logic [63:0]    mu_x_q;
	logic [OB-1:0]  mu_y_q;
	logic [MCW-1:0] mu_cnt_q;
	logic           mu_ovf;
	logic [63:0]    mu_prod;

	// output register
	logic           ovalid_q;
	logic [63:0]    onum_q;
	logic [62:0]    oden_q;
	status_t        osts_q;

	logic           accept, zero_den, out_free, lim_ovf;
	logic [EW-1:0]  e_sat;

	function automatic logic [OB-1:0] mag(input logic [OB-1:0] v);
		mag = v[OB-1] ? (~v + {{(OB-1){1'b0}}, 1'b1}) : v;
	endfunction

	assign accept   = din.valid && din.ready;
	assign din.ready = (state_q == ST_IDLE);
	assign out_free = !ovalid_q || dout.ready;
	assign e_sat    = (32'(din.exponent) > MAX_EXPONENT) ? EW'(MAX_EXPONENT) : EW'(din.exponent);
	assign zero_den = (ad_q == '0) || ((op_q == OP_ADD || op_q == OP_MUL) && bd_q == '0);
	assign lim_ovf  = wd_q[63] || (wn_q[63] && !(wneg_q && wn_q[62:0] == '0));

	assign dout.valid   = ovalid_q;
	assign dout.res_num = onum_q;
	assign dout.res_den = oden_q;
	assign dout.status  = osts_q;

	// divider step
	assign dv_sh    = {dv_rem_q[63:0], dv_quo_q[63]};
	assign dv_ge    = dv_sh >= {1'b0, dv_den_q};
	assign dv_rem_n = dv_ge ? (dv_sh - {1'b0, dv_den_q}) : dv_sh;

	// multiplier step, msb of y first
	assign mu_acc_n = {mu_acc_q[MW-2:0], 1'b0} + (mu_y_q[OB-1] ? {{OB{1'b0}}, mu_x_q} : '0);
	assign mu_ovf   = |mu_acc_q[MW-1:WORD_BITS];
	assign mu_prod  = mu_acc_q[63:0];

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINAL && out_free)
				ovalid_q <= 1'b1;
			else if (dout.ready)
				ovalid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_START;
			ST_START: state_d = zero_den ? ST_FINAL : ST_RED0;
			ST_RED0:  state_d = (wn_q == '0) ? red_ret_q : ST_DIV;
			ST_RED1:  state_d = ST_DIV;
			ST_RED2:  state_d = ST_DIV;
			ST_RED3:  state_d = red_ret_q;
			ST_DIV:   if (dv_cnt_q == '1) state_d = ret_q;
			ST_MUL:   if (mu_cnt_q == MCW'(OB - 1)) state_d = ret_q;
			ST_FB:    state_d = ST_RED0;
			ST_FA: begin
				case (op_q)
					OP_REDUCE: state_d = ST_FINAL;
					OP_POW:    state_d = ST_P0;
					default:   state_d = ST_MUL;
				endcase
			end
			ST_M1:    state_d = ST_MUL;
			ST_M2:    state_d = ST_RED0;
			ST_A1:    state_d = ST_MUL;
			ST_A2:    state_d = ST_MUL;
			ST_A3:    state_d = ST_RED0;
			ST_P0:    state_d = (cnt_q == '0) ? ST_FINAL : ST_MUL;
			ST_P1:    state_d = mu_ovf ? ST_FINAL : ST_MUL;
			ST_P2:    state_d = mu_ovf ? ST_FINAL : ST_RED0;
			ST_FINAL: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath and unit sequencing
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q   <= opcode_t'(din.opcode);
					an_q   <= mag(din.num_a);
					ad_q   <= mag(din.den_a);
					bn_q   <= mag(din.num_b);
					bd_q   <= mag(din.den_b);
					aneg_q <= din.num_a[OB-1] ^ din.den_a[OB-1];
					bneg_q <= din.num_b[OB-1] ^ din.den_b[OB-1];
					cnt_q  <= e_sat;
					sts_q  <= STS_OK;
				end
			end
			ST_START: begin
				if (zero_den) begin
					sts_q <= STS_ZERO_DEN;
				end else if (op_q == OP_ADD || op_q == OP_MUL) begin
					wn_q      <= 64'(bn_q);
					wd_q      <= 64'(bd_q);
					wneg_q    <= bneg_q;
					red_ret_q <= ST_FB;
				end else begin
					wn_q      <= 64'(an_q);
					wd_q      <= 64'(ad_q);
					wneg_q    <= aneg_q;
					red_ret_q <= ST_FA;
				end
			end
			// reduce: gcd by remainders, then divide both terms
			ST_RED0: begin
				if (wn_q == '0) begin
					wneg_q <= 1'b0;
					wd_q   <= 64'd1;
				end else begin
					dv_rem_q <= '0;
					dv_quo_q <= wn_q;
					dv_den_q <= wd_q;
					dv_cnt_q <= '0;
					gy_q     <= wd_q;
					ret_q    <= ST_RED1;
				end
			end
			ST_RED1: begin
				dv_rem_q <= '0;
				dv_cnt_q <= '0;
				if (dv_rem_q[63:0] == '0) begin
					dv_quo_q <= wn_q;
					dv_den_q <= gy_q;
					ret_q    <= ST_RED2;
				end else begin
					dv_quo_q <= gy_q;
					dv_den_q <= dv_rem_q[63:0];
					gy_q     <= dv_rem_q[63:0];
					ret_q    <= ST_RED1;
				end
			end
			ST_RED2: begin
				wn_q     <= dv_quo_q;
				dv_rem_q <= '0;
				dv_quo_q <= wd_q;
				dv_den_q <= gy_q;
				dv_cnt_q <= '0;
				ret_q    <= ST_RED3;
			end
			ST_RED3: wd_q <= dv_quo_q;
			ST_DIV: begin
				dv_rem_q <= dv_rem_n;
				dv_quo_q <= {dv_quo_q[62:0], dv_ge};
				dv_cnt_q <= dv_cnt_q + 1'b1;
			end
			ST_MUL: begin
				mu_acc_q <= mu_acc_n;
				mu_y_q   <= {mu_y_q[OB-2:0], 1'b0};
				mu_cnt_q <= mu_cnt_q + 1'b1;
			end
			// b reduced, now reduce a
			ST_FB: begin
				bn_q      <= wn_q[OB-1:0];
				bd_q      <= wd_q[OB-1:0];
				bneg_q    <= wneg_q;
				wn_q      <= 64'(an_q);
				wd_q      <= 64'(ad_q);
				wneg_q    <= aneg_q;
				red_ret_q <= ST_FA;
			end
			// a reduced, dispatch on opcode
			ST_FA: begin
				an_q     <= wn_q[OB-1:0];
				ad_q     <= wd_q[OB-1:0];
				aneg_q   <= wneg_q;
				mu_acc_q <= '0;
				mu_cnt_q <= '0;
				mu_x_q   <= wn_q;
				case (op_q)
					OP_MUL: begin
						mu_y_q <= bn_q;
						ret_q  <= ST_M1;
					end
					OP_ADD: begin
						mu_y_q <= bd_q;
						ret_q  <= ST_A1;
					end
					OP_POW: begin
						wn_q   <= 64'd1;
						wd_q   <= 64'd1;
						wneg_q <= 1'b0;
					end
					default: ;
				endcase
			end
			ST_M1: begin
				t1_q     <= mu_prod;
				mu_acc_q <= '0;
				mu_cnt_q <= '0;
				mu_x_q   <= 64'(ad_q);
				mu_y_q   <= bd_q;
				ret_q    <= ST_M2;
			end
			ST_M2: begin
				wn_q      <= t1_q;
				wd_q      <= mu_prod;
				wneg_q    <= aneg_q ^ bneg_q;
				red_ret_q <= ST_FINAL;
			end
			ST_A1: begin
				t1_q     <= mu_prod;
				mu_acc_q <= '0;
				mu_cnt_q <= '0;
				mu_x_q   <= 64'(bn_q);
				mu_y_q   <= ad_q;
				ret_q    <= ST_A2;
			end
			ST_A2: begin
				t2_q     <= mu_prod;
				mu_acc_q <= '0;
				mu_cnt_q <= '0;
				mu_x_q   <= 64'(ad_q);
				mu_y_q   <= bd_q;
				ret_q    <= ST_A3;
			end
			// signed sum of cross products
			ST_A3: begin
				wd_q      <= mu_prod;
				red_ret_q <= ST_FINAL;
				if (aneg_q == bneg_q) begin
					wn_q   <= t1_q + t2_q;
					wneg_q <= aneg_q;
				end else if (t1_q >= t2_q) begin
					wn_q   <= t1_q - t2_q;
					wneg_q <= aneg_q;
				end else begin
					wn_q   <= t2_q - t1_q;
					wneg_q <= bneg_q;
				end
			end
			// power loop: multiply by a, check width, reduce
			ST_P0: begin
				mu_acc_q <= '0;
				mu_cnt_q <= '0;
				mu_x_q   <= wn_q;
				mu_y_q   <= an_q;
				ret_q    <= ST_P1;
			end
			ST_P1: begin
				if (mu_ovf) begin
					sts_q <= STS_OVERFLOW;
				end else begin
					t1_q     <= mu_prod;
					mu_acc_q <= '0;
					mu_cnt_q <= '0;
					mu_x_q   <= wd_q;
					mu_y_q   <= ad_q;
					ret_q    <= ST_P2;
				end
			end
			ST_P2: begin
				if (mu_ovf) begin
					sts_q <= STS_OVERFLOW;
				end else begin
					wn_q      <= t1_q;
					wd_q      <= mu_prod;
					wneg_q    <= wneg_q ^ aneg_q;
					cnt_q     <= cnt_q - 1'b1;
					red_ret_q <= ST_P0;
				end
			end
			// range check and result load
			ST_FINAL: begin
				if (out_free) begin
					if (sts_q != STS_OK) begin
						onum_q <= '0;
						oden_q <= '0;
						osts_q <= sts_q;
					end else if (lim_ovf) begin
						onum_q <= '0;
						oden_q <= '0;
						osts_q <= STS_OVERFLOW;
					end else begin
						onum_q <= wneg_q ? (64'd0 - wn_q) : wn_q;
						oden_q <= wd_q[62:0];
						osts_q <= STS_OK;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

/* tb/rar_checker.sv */
// checker for the rational arithmetic reduce block: predicts each result and compares it
module rar_checker
	import rar_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rar_in_if    din,
	rar_out_if   dout,
	output int   fails,
	output int   waiting,
	output int   checked,
	output int   flagged
);

	localparam int OPB = 16;
	localparam int MAX_EXP = 15;
	localparam logic [63:0] POS_LIM = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;

	typedef struct {
		bit          neg;
		logic [63:0] n;
		logic [63:0] d;
	} frac_t;

	typedef struct {
		logic signed [63:0] num;
		logic [62:0]        den;
		status_t            status;
	} fraction_out_t;

	fraction_out_t fractions_due[$];

	// sign and magnitude of one operand field
	function automatic void split(input logic [OPB-1:0] raw, output bit neg,
		output logic [63:0] mag);
		logic [OPB-1:0] m;
		neg = raw[OPB-1];
		m = neg ? -raw : raw;
		mag = 64'(m);
	endfunction

	function automatic frac_t to_frac(input logic [OPB-1:0] rn, input logic [OPB-1:0] rd);
		frac_t f;
		bit sn, sd;
		split(rn, sn, f.n);
		split(rd, sd, f.d);
		f.neg = sn != sd;
		return f;
	endfunction

	function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// lowest terms, zero as 0/1
	function automatic frac_t lowest_terms(input frac_t f);
		logic [63:0] g;
		if (f.n == 0) begin
			f.neg = 0;
			f.d = 1;
			return f;
		end
		g = euclid_gcd(f.n, f.d);
		f.n = f.n / g;
		f.d = f.d / g;
		return f;
	endfunction

	function automatic fraction_out_t compute_fraction(input logic [1:0] op,
		input logic [OPB-1:0] na, input logic [OPB-1:0] da,
		input logic [OPB-1:0] nb, input logic [OPB-1:0] db, input logic [3:0] ex);
		frac_t a, b, r, t;
		logic [63:0] p, q;
		logic [127:0] wn, wd;
		int e;
		status_t st;
		fraction_out_t o;
		a = to_frac(na, da);
		b = to_frac(nb, db);
		e = (ex > MAX_EXP) ? MAX_EXP : ex;
		st = STS_OK;
		r = a;
		if (a.d == 0 || ((op == OP_ADD || op == OP_MUL) && b.d == 0)) begin
			st = STS_ZERO_DEN;
		end else begin
			a = lowest_terms(a);
			case (op)
				OP_REDUCE: r = a;
				OP_ADD: begin
					b = lowest_terms(b);
					p = a.n * b.d;
					q = b.n * a.d;
					if (a.neg == b.neg) begin
						r.n = p + q;
						r.neg = a.neg;
					end else if (p >= q) begin
						r.n = p - q;
						r.neg = a.neg;
					end else begin
						r.n = q - p;
						r.neg = b.neg;
					end
					r.d = a.d * b.d;
					r = lowest_terms(r);
				end
				OP_MUL: begin
					b = lowest_terms(b);
					r.n = a.n * b.n;
					r.d = a.d * b.d;
					r.neg = a.neg != b.neg;
					r = lowest_terms(r);
				end
				default: begin
					r.neg = 0;
					r.n = 1;
					r.d = 1;
					for (int i = 0; i < e && st == STS_OK; i++) begin
						wn = 128'(r.n) * 128'(a.n);
						wd = 128'(r.d) * 128'(a.d);
						if (wn[127:64] != 0 || wd[127:64] != 0) begin
							st = STS_OVERFLOW;
						end else begin
							t.n = wn[63:0];
							t.d = wd[63:0];
							t.neg = r.neg != a.neg;
							r = lowest_terms(t);
						end
					end
				end
			endcase
			if (st == STS_OK && (r.n > (r.neg ? NEG_LIM : POS_LIM) || r.d > POS_LIM))
				st = STS_OVERFLOW;
		end
		if (st != STS_OK) begin
			o.num = 0;
			o.den = 0;
		end else begin
			o.num = r.neg ? -r.n : r.n;
			o.den = r.d[62:0];
		end
		o.status = st;
		return o;
	endfunction

	// queue expected fraction on each accepted input item, compare on each output item
	always @(posedge clk or negedge arst_n) begin
		fraction_out_t e;
		int errs;
		if (!arst_n) begin
			fails <= 0;
			waiting <= 0;
			checked <= 0;
			flagged <= 0;
		end else begin
			errs = 0;
			if (din.valid && din.ready)
				fractions_due.push_back(compute_fraction(din.opcode, din.num_a, din.den_a,
					din.num_b, din.den_b, din.exponent));
			if (dout.valid && dout.ready) begin
				if (fractions_due.size() == 0) begin
					$error("unexpected result item: num %0d den %0d status %0d",
						dout.res_num, dout.res_den, dout.status);
					errs++;
				end else begin
					e = fractions_due.pop_front();
					checked <= checked + 1;
					if (e.status != STS_OK)
						flagged <= flagged + 1;
					if (dout.res_num !== e.num) begin
						$error("res_num: expected %0d actual %0d", e.num, dout.res_num);
						errs++;
					end
					if (dout.res_den !== e.den) begin
						$error("res_den: expected %0d actual %0d", e.den, dout.res_den);
						errs++;
					end
					if (dout.status !== e.status) begin
						$error("status: expected %0d actual %0d", e.status, dout.status);
						errs++;
					end
				end
			end
			fails <= fails + errs;
			waiting <= fractions_due.size();
		end
	end

endmodule

/* tb/tb.sv */
// testbench top for the rational arithmetic reduce block: stimulus, idling and verdict
module tb;
	import rar_pkg::*;

	localparam longint CYCLE_LIMIT = 200_000_000;
	localparam int RANDOM_ITEMS = 880;

	logic clk = 0;
	logic arst_n = 0;
	longint cycles = 0;
	bit quiet = 0;
	int pressure_req = 0;
	int pressure_seen = 0;
	int hold = 0;
	int fails, waiting, checked, flagged;
	int sent = 0;

	rar_in_if #(.OPERAND_BITS(16)) din_ch();
	rar_out_if dout_ch();

	rational_arith_reduce_top dut (.clk(clk), .arst_n(arst_n), .din(din_ch), .dout(dout_ch));

	rar_checker chk (.clk(clk), .arst_n(arst_n), .din(din_ch), .dout(dout_ch),
		.fails(fails), .waiting(waiting), .checked(checked), .flagged(flagged));

	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stalls, free running when quiet, one long hold-off on request
	always @(posedge clk) begin
		int r;
		if (pressure_req != pressure_seen) begin
			pressure_seen <= pressure_req;
			hold <= 3000;
			dout_ch.ready <= 0;
		end else if (hold > 0) begin
			hold <= hold - 1;
			dout_ch.ready <= 0;
		end else if (quiet) begin
			dout_ch.ready <= 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65)
				dout_ch.ready <= 1;
			else begin
				hold <= (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 80);
				dout_ch.ready <= 0;
			end
		end
	end

	// offer one item and wait until it is taken
	task automatic send_item(input opcode_t op, input logic [15:0] na, input logic [15:0] da,
		input logic [15:0] nb, input logic [15:0] db, input logic [3:0] ex);
		int gap;
		gap = 0;
		if (!quiet)
			gap = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
		if (gap > 0) begin
			din_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		din_ch.valid <= 1;
		din_ch.opcode <= op;
		din_ch.num_a <= na;
		din_ch.den_a <= da;
		din_ch.num_b <= nb;
		din_ch.den_b <= db;
		din_ch.exponent <= ex;
		do @(posedge clk); while (!din_ch.ready);
		sent++;
	endtask

	// operand value: small, full range or extreme
	function automatic logic [15:0] pick_operand();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 16'($signed($urandom_range(0, 40)) - 20);
		else if (r < 90)
			return 16'($urandom);
		else
			case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'hffff;
				default: return 16'h0001;
			endcase
	endfunction

	task automatic send_random();
		opcode_t op;
		logic [15:0] na, da;
		logic [3:0] ex;
		op = opcode_t'($urandom_range(0, 3));
		na = pick_operand();
		da = pick_operand();
		ex = 4'($urandom);
		// most powers use small bases or small exponents to keep the run short
		if (op == OP_POW && $urandom_range(0, 99) < 80) begin
			if ($urandom_range(0, 1))
				ex = 4'($urandom_range(0, 4));
			else begin
				na = 16'($signed($urandom_range(0, 40)) - 20);
				da = 16'($signed($urandom_range(0, 40)) - 20);
			end
		end
		send_item(op, na, da, pick_operand(), pick_operand(), ex);
	endtask

	initial begin
		din_ch.valid = 0;
		din_ch.opcode = OP_REDUCE;
		din_ch.num_a = 0;
		din_ch.den_a = 1;
		din_ch.num_b = 0;
		din_ch.den_b = 1;
		din_ch.exponent = 0;
		dout_ch.ready = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every operation, zero and overflow cases
		send_item(OP_REDUCE, 16'd6, -16'sd4, 16'd0, 16'd0, 4'd0);
		send_item(OP_REDUCE, 16'h8000, 16'h8000, 16'h7fff, 16'hffff, 4'hf);
		send_item(OP_REDUCE, 16'd0, -16'sd5, 16'd1, 16'd1, 4'd0);
		send_item(OP_REDUCE, 16'h7fff, 16'h8000, 16'd1, 16'd1, 4'd0);
		send_item(OP_REDUCE, 16'd3, 16'd0, 16'd1, 16'd1, 4'd0);
		send_item(OP_ADD, -16'sd1, 16'd2, 16'd1, 16'd3, 4'd0);
		send_item(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd0, 4'd0);
		send_item(OP_ADD, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 4'd0);
		send_item(OP_ADD, 16'd1, 16'd2, -16'sd1, 16'd2, 4'd0);
		send_item(OP_ADD, 16'd1, 16'd3, 16'd2, -16'sd3, 4'd0);
		send_item(OP_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1, 4'd0);
		send_item(OP_MUL, 16'd0, 16'd7, -16'sd5, 16'd3, 4'd0);
		send_item(OP_MUL, 16'd5, 16'd3, 16'd2, 16'd0, 4'd0);
		send_item(OP_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 4'd0);
		send_item(OP_POW, 16'd0, 16'd3, 16'd0, 16'd0, 4'd0);
		send_item(OP_POW, 16'd0, -16'sd3, 16'd0, 16'd0, 4'd5);
		send_item(OP_POW, 16'h8000, 16'd1, 16'd0, 16'd0, 4'd15);
		send_item(OP_POW, 16'h8000, 16'd1, 16'd0, 16'd0, 4'd4);
		send_item(OP_POW, 16'h7fff, 16'h8000, 16'd1, 16'd1, 4'd4);
		send_item(OP_POW, 16'h7fff, 16'h8000, 16'd1, 16'd1, 4'd5);
		send_item(OP_POW, 16'd19, 16'd1, 16'd0, 16'd0, 4'd15);
		send_item(OP_POW, -16'sd19, 16'd1, 16'd0, 16'd0, 4'd15);
		send_item(OP_POW, -16'sd3, 16'd2, 16'd0, 16'd0, 4'd15);
		send_item(OP_POW, 16'd1, 16'd0, 16'd1, 16'd1, 4'd2);

		// random in three phases: idling, no idling, idling with a long result hold-off
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= RANDOM_ITEMS / 3) && (i < 2 * RANDOM_ITEMS / 3);
			if (i == 2 * RANDOM_ITEMS / 3 + 10)
				pressure_req = pressure_req + 1;
			send_random();
		end
		din_ch.valid <= 0;
		quiet = 0;

		while (waiting != 0 || checked != sent) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("%0d items sent over all four operations, %0d results checked", sent, checked);
		$display("%0d results flagged as zero denominator or overflow", flagged);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
